FILE: src/session_table_lru_aging_top_defines.svh
// Assertion macros for the session table checker
`ifndef SESSION_TABLE_LRU_AGING_TOP_DEFINES_SVH
`define SESSION_TABLE_LRU_AGING_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define STL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/stl_pkg.sv
// Shared types and constants of the session table
`default_nettype none
package stl_pkg;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [63:0] hi;
    logic [63:0] lo;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [31:0] cnt;
    logic [31:0] ls;
  } ent_t;

  typedef enum logic [1:0] {
    REQ_MSG  = 2'd0,
    REQ_SHUT = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_APPEND  = 3'd1,
    ST_REPLACE = 3'd2,
    ST_REMOVED = 3'd3,
    ST_MISSED  = 3'd4,
    ST_TICK    = 3'd5
  } status_t;

  typedef enum logic {
    CFG_IDLE_TIMEOUT = 1'b0,
    CFG_SWEEP_PERIOD = 1'b1
  } cfg_idx_t;

  // per-cell command
  typedef enum logic [2:0] {
    C_HOLD,
    C_NEW,
    C_INC,
    C_SHL,
    C_COPY
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_DECIDE,
    S_SCAN,
    S_REPL,
    S_SWEEP
  } state_t;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd300;
  localparam logic [7:0]  SWEEP_PERIOD_RST = 8'd60;

endpackage
`default_nettype wire

FILE: src/stl_cell.sv
// One table cell: an entry, its key compare and its load/shift paths
`default_nettype none
module stl_cell
  import stl_pkg::*;
(
  input  wire logic        clk,
  input  wire cell_op_t    op,
  input  wire ent_t        nbr,
  input  wire ent_t        wr_ent,
  input  wire key_t        key,
  input  wire logic [31:0] now,
  output ent_t             ent,
  output logic             match_r
);

  ent_t ent_r;
  ent_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    unique case (op)
      C_NEW: begin
        ent_nxt.key = key;
        ent_nxt.cnt = 32'd1;
        ent_nxt.ls  = now;
      end
      C_INC: begin
        ent_nxt.cnt = ent_r.cnt + 32'd1;
        ent_nxt.ls  = now;
      end
      C_SHL:   ent_nxt = nbr;
      C_COPY:  ent_nxt = wr_ent;
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r   <= ent_nxt;
    match_r <= (ent_r.key == key);
  end

  assign ent = ent_r;

endmodule
`default_nettype wire

FILE: src/session_table_lru_aging_top.sv
// Session table top level: control sequencer around a row of entry cells
//
// Sequencing: a message hit, append or shutdown passes through key
// capture, per-cell compare and update before the out_strobe pulse. A
// message miss on a full table scans last-seen times one cell a cycle
// through a read mux. A tick without sweep strobes straight from idle;
// a tick with sweep walks every valid cell once after the start cycle,
// compacting in order (an empty table is not swept). Results are pulsed
// for one cycle on out_strobe and cannot be held off; busy is low in the
// strobe cycle, so a new start may coincide.
`default_nettype none
module session_table_lru_aging_top
  import stl_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_src_ip,
  input  wire logic [15:0] in_src_port,
  input  wire logic [63:0] in_uuid_upper,
  input  wire logic [63:0] in_uuid_lower,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  output logic             out_strobe,
  output logic [2:0]       out_status,
  output logic [31:0]      out_msg_count,
  output logic [7:0]       out_evicted,
  output logic [7:0]       out_occupancy
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW = $clog2(TABLE_DEPTH + 1);
  localparam logic [FW-1:0] FULL = FW'(TABLE_DEPTH);

  state_t         state_r, state_nxt;
  req_t           req_r, req_nxt;
  key_t           key_r, key_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [31:0]    clock_r, clock_nxt;
  logic [7:0]     timer_r, timer_nxt;
  logic [15:0]    timeout_r;
  logic [7:0]     period_r;
  logic [IW-1:0]  rd_r, rd_nxt;
  logic [IW-1:0]  wp_r, wp_nxt;
  logic [IW-1:0]  cidx_r, cidx_nxt;
  logic [31:0]    cand_r, cand_nxt;
  logic [7:0]     ev_r, ev_nxt;

  logic           ostb_r, ostb_nxt;
  logic [2:0]     ost_r, ost_nxt;
  logic [31:0]    ocnt_r, ocnt_nxt;
  logic [7:0]     oev_r, oev_nxt;
  logic [7:0]     oocc_r, oocc_nxt;

  ent_t           ents  [TABLE_DEPTH];
  logic           match [TABLE_DEPTH];
  cell_op_t       ops   [TABLE_DEPTH];

  logic           hit_any;
  logic [IW-1:0]  hit_idx;
  ent_t           rd_ent;
  logic           rd_last;
  logic [7:0]     tick_t;
  logic           expired;

  // cell row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ent_t nbr;
    if (i == TABLE_DEPTH - 1) begin : g_end
      assign nbr = ents[i];
    end else begin : g_mid
      assign nbr = ents[i+1];
    end
    stl_cell u_cell (
      .clk    (clk),
      .op     (ops[i]),
      .nbr    (nbr),
      .wr_ent (rd_ent),
      .key    (key_r),
      .now    (clock_r),
      .ent    (ents[i]),
      .match_r(match[i])
    );
  end

  // keys are unique among valid cells: at most one hit
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match[i] && (FW'(i) < fill_r)) begin
        hit_any = 1'b1;
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign rd_ent  = ents[rd_r];
  assign rd_last = ({{(FW-IW){1'b0}}, rd_r} + FW'(1)) >= fill_r;
  assign tick_t  = timer_r + 8'd1;
  assign expired = (clock_r - rd_ent.ls) > {16'd0, timeout_r};

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    key_nxt   = key_r;
    fill_nxt  = fill_r;
    clock_nxt = clock_r;
    timer_nxt = timer_r;
    rd_nxt    = rd_r;
    wp_nxt    = wp_r;
    cidx_nxt  = cidx_r;
    cand_nxt  = cand_r;
    ev_nxt    = ev_r;
    ostb_nxt  = 1'b0;
    ost_nxt   = ost_r;
    ocnt_nxt  = ocnt_r;
    oev_nxt   = oev_r;
    oocc_nxt  = oocc_r;
    for (int i = 0; i < TABLE_DEPTH; i++) ops[i] = C_HOLD;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt  = req_t'(in_req_type);
          key_nxt  = '{addr: in_src_ip, port: in_src_port,
                       hi: in_uuid_upper, lo: in_uuid_lower};
          ocnt_nxt = '0;
          oev_nxt  = '0;
          oocc_nxt = 8'(fill_r);
          unique case (req_t'(in_req_type))
            REQ_MSG, REQ_SHUT: state_nxt = S_MATCH;
            REQ_TICK: begin
              clock_nxt = clock_r + 32'd1;
              if (tick_t >= period_r) begin
                timer_nxt = '0;
                rd_nxt    = '0;
                wp_nxt    = '0;
                ev_nxt    = '0;
                if (fill_r == '0) begin
                  ostb_nxt = 1'b1;
                  ost_nxt  = ST_TICK;
                end else begin
                  state_nxt = S_SWEEP;
                end
              end else begin
                timer_nxt = tick_t;
                ostb_nxt  = 1'b1;
                ost_nxt   = ST_TICK;
              end
            end
            default: begin
              ostb_nxt = 1'b1;
              ost_nxt  = ST_MISSED;
            end
          endcase
        end
      end
      S_MATCH: state_nxt = S_DECIDE;
      S_DECIDE: begin
        state_nxt = S_IDLE;
        ostb_nxt  = 1'b1;
        if (req_r == REQ_MSG) begin
          if (hit_any) begin
            ops[hit_idx] = C_INC;
            ocnt_nxt     = ents[hit_idx].cnt + 32'd1;
            ost_nxt      = ST_HIT;
          end else if (fill_r < FULL) begin
            ops[fill_r[IW-1:0]] = C_NEW;
            fill_nxt = fill_r + FW'(1);
            oocc_nxt = 8'(fill_r + FW'(1));
            ocnt_nxt = 32'd1;
            ost_nxt  = ST_APPEND;
          end else begin
            ostb_nxt  = 1'b0;
            state_nxt = S_SCAN;
            rd_nxt    = '0;
            cidx_nxt  = '0;
            cand_nxt  = clock_r;
          end
        end else begin
          if (hit_any) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if ((IW'(i) >= hit_idx) && (FW'(i + 1) < fill_r)) ops[i] = C_SHL;
            end
            fill_nxt = fill_r - FW'(1);
            oocc_nxt = 8'(fill_r - FW'(1));
            ost_nxt  = ST_REMOVED;
          end else begin
            ost_nxt  = ST_MISSED;
          end
        end
      end
      S_SCAN: begin
        if (rd_ent.ls < cand_r) begin
          cand_nxt = rd_ent.ls;
          cidx_nxt = rd_r;
        end
        rd_nxt = rd_r + IW'(1);
        if (rd_last) state_nxt = S_REPL;
      end
      S_REPL: begin
        ops[cidx_r] = C_NEW;
        state_nxt   = S_IDLE;
        ostb_nxt    = 1'b1;
        ocnt_nxt    = 32'd1;
        ost_nxt     = ST_REPLACE;
      end
      S_SWEEP: begin
        // read pointer walks ahead, survivors are copied down to wp
        if (expired) begin
          ev_nxt = ev_r + 8'd1;
        end else begin
          ops[wp_r] = C_COPY;
          wp_nxt    = wp_r + IW'(1);
        end
        rd_nxt = rd_r + IW'(1);
        if (rd_last) begin
          state_nxt = S_IDLE;
          fill_nxt  = FW'(wp_r) + (expired ? FW'(0) : FW'(1));
          oocc_nxt  = 8'(FW'(wp_r) + (expired ? FW'(0) : FW'(1)));
          oev_nxt   = expired ? ev_r + 8'd1 : ev_r;
          ost_nxt   = ST_TICK;
          ostb_nxt  = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      clock_r   <= '0;
      timer_r   <= '0;
      timeout_r <= IDLE_TIMEOUT_RST;
      period_r  <= SWEEP_PERIOD_RST;
      ostb_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      clock_r <= clock_nxt;
      timer_r <= timer_nxt;
      ostb_r  <= ostb_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_addr))
          CFG_IDLE_TIMEOUT: timeout_r <= cfg_wdata;
          CFG_SWEEP_PERIOD: period_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    key_r  <= key_nxt;
    rd_r   <= rd_nxt;
    wp_r   <= wp_nxt;
    cidx_r <= cidx_nxt;
    cand_r <= cand_nxt;
    ev_r   <= ev_nxt;
    ost_r  <= ost_nxt;
    ocnt_r <= ocnt_nxt;
    oev_r  <= oev_nxt;
    oocc_r <= oocc_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_strobe    = ostb_r;
  assign out_status    = ost_r;
  assign out_msg_count = ocnt_r;
  assign out_evicted   = oev_r;
  assign out_occupancy = oocc_r;

endmodule
`default_nettype wire

FILE: src/stl_chk.sv
// Port-level checker for the session table, bound to the top level
`default_nettype none
`include "session_table_lru_aging_top_defines.svh"
module stl_chk
  import stl_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
)(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_req_type,
  input wire logic        out_strobe,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_msg_count,
  input wire logic [7:0]  out_evicted,
  input wire logic [7:0]  out_occupancy
);

  logic msg_word;
  logic lookup_req;

  assign msg_word   = (out_status == ST_HIT) || (out_status == ST_APPEND) ||
                      (out_status == ST_REPLACE);
  assign lookup_req = (in_req_type == REQ_MSG) || (in_req_type == REQ_SHUT);

  `STL_ASSERT_NOW(a_occ_bound, out_strobe, out_occupancy <= 8'(TABLE_DEPTH), "occupancy over depth")
  `STL_ASSERT_NOW(a_cnt_zero, out_strobe && !msg_word, out_msg_count == 32'd0, "count on non-message word")
  `STL_ASSERT_NOW(a_ev_tick, out_strobe && out_status != ST_TICK, out_evicted == 8'd0, "evictions outside tick")
  `STL_ASSERT_NOW(a_word_idle, out_strobe, !busy, "word while busy")
  `STL_ASSERT_NEXT(a_lookup_busy, start && !busy && lookup_req, busy, "lookup not started")

endmodule

bind session_table_lru_aging_top stl_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_stl_chk (.*);
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the session table with LRU replacement and idle aging
`default_nettype none

class session_scoreboard;
  typedef struct {
    stl_pkg::status_t st;
    logic [31:0]      cnt;
    logic [7:0]       ev;
    logic [7:0]       occ;
  } outcome_t;

  // mirrored table state
  stl_pkg::key_t keys[128];
  logic [31:0]   hits[128];
  logic [31:0]   seen[128];
  int            fill;
  logic [31:0]   now_sec;
  logic [7:0]    timer;
  logic [15:0]   timeout;
  logic [7:0]    period;

  outcome_t      pending_q[$];
  int            errors;
  int            results;
  int            status_seen[8];
  int            swept_total;

  function new();
    fill = 0;
    now_sec = '0;
    timer = '0;
    timeout = stl_pkg::IDLE_TIMEOUT_RST;
    period = stl_pkg::SWEEP_PERIOD_RST;
    errors = 0;
    results = 0;
    swept_total = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  function void set_reg(stl_pkg::cfg_idx_t idx, logic [15:0] val);
    if (idx == stl_pkg::CFG_IDLE_TIMEOUT) timeout = val;
    else period = val[7:0];
  endfunction

  function int find_key(stl_pkg::key_t k);
    for (int i = 0; i < fill; i++)
      if (keys[i] == k) return i;
    return -1;
  endfunction

  // note an accepted request word and queue its expected outcome
  function void note_request(stl_pkg::req_t r, stl_pkg::key_t k);
    outcome_t e;
    int idx;
    int w;
    logic [31:0] oldest;
    e.st = stl_pkg::ST_MISSED;
    e.cnt = '0;
    e.ev = '0;
    case (r)
      stl_pkg::REQ_MSG: begin
        idx = find_key(k);
        if (idx >= 0) begin
          e.st = stl_pkg::ST_HIT;
        end else begin
          if (fill < 128) begin
            idx = fill;
            fill++;
            e.st = stl_pkg::ST_APPEND;
          end else begin
            oldest = now_sec;
            idx = 0;
            for (int i = 0; i < fill; i++)
              if (seen[i] < oldest) begin
                oldest = seen[i];
                idx = i;
              end
            e.st = stl_pkg::ST_REPLACE;
          end
          keys[idx] = k;
          hits[idx] = '0;
        end
        hits[idx] = hits[idx] + 32'd1;
        seen[idx] = now_sec;
        e.cnt = hits[idx];
      end
      stl_pkg::REQ_SHUT: begin
        idx = find_key(k);
        if (idx >= 0) begin
          for (int i = idx; i + 1 < fill; i++) begin
            keys[i] = keys[i+1];
            hits[i] = hits[i+1];
            seen[i] = seen[i+1];
          end
          fill--;
          e.st = stl_pkg::ST_REMOVED;
        end
      end
      stl_pkg::REQ_TICK: begin
        now_sec = now_sec + 32'd1;
        timer = timer + 8'd1;
        if (timer >= period) begin
          timer = '0;
          w = 0;
          for (int i = 0; i < fill; i++) begin
            if (32'(now_sec - seen[i]) > {16'd0, timeout}) begin
              e.ev++;
            end else begin
              keys[w] = keys[i];
              hits[w] = hits[i];
              seen[w] = seen[i];
              w++;
            end
          end
          fill = w;
          swept_total += e.ev;
        end
        e.st = stl_pkg::ST_TICK;
      end
      default: ;
    endcase
    e.occ = 8'(fill);
    pending_q.push_back(e);
  endfunction

  function void check_result(logic [2:0] st, logic [31:0] cnt, logic [7:0] ev,
                             logic [7:0] occ);
    outcome_t e;
    results++;
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word: status %0d count %0d", st, cnt);
      return;
    end
    e = pending_q.pop_front();
    status_seen[e.st]++;
    if (st !== e.st || cnt !== e.cnt || ev !== e.ev || occ !== e.occ) begin
      errors++;
      if (errors <= 10)
        $display("result %0d: exp st=%0d cnt=%0d ev=%0d occ=%0d, got %0d %0d %0d %0d",
                 results, e.st, e.cnt, e.ev, e.occ, st, cnt, ev, occ);
    end
  endfunction
endclass

module tb;
  import stl_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [31:0] in_src_ip;
  logic [15:0] in_src_port;
  logic [63:0] in_uuid_upper;
  logic [63:0] in_uuid_lower;
  logic        cfg_we;
  logic        cfg_addr;
  logic [15:0] cfg_wdata;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [31:0] out_msg_count;
  logic [7:0]  out_evicted;
  logic [7:0]  out_occupancy;

  session_scoreboard sb;
  key_t key_pool[256];
  int   burst_left;
  int   words_sent;

  session_table_lru_aging_top u_dut (
    .clk, .rst_n, .start, .busy,
    .in_req_type, .in_src_ip, .in_src_port, .in_uuid_upper, .in_uuid_lower,
    .cfg_we, .cfg_addr, .cfg_wdata,
    .out_strobe, .out_status, .out_msg_count, .out_evicted, .out_occupancy
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 1500000);
    $display("session_table_lru_aging_top: mismatch");
    $finish;
  end

  always @(posedge clk)
    if (rst_n && out_strobe)
      sb.check_result(out_status, out_msg_count, out_evicted, out_occupancy);

  function automatic key_t random_key();
    key_t k;
    k.addr = $urandom;
    k.port = 16'($urandom);
    k.hi = {$urandom, $urandom};
    k.lo = {$urandom, $urandom};
    return k;
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_word(req_t r, key_t k);
    in_req_type = r;
    in_src_ip = k.addr;
    in_src_port = k.port;
    in_uuid_upper = k.hi;
    in_uuid_lower = k.lo;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r, k);
    words_sent++;
    @(negedge clk);
    if (burst_left <= 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // block idle: nothing queued, and a full-table scan has surely finished
  task automatic drain();
    start = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_words(int n, int pool_sz);
    int   p;
    req_t r;
    key_t k;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 55) r = REQ_MSG;
      else if (p < 70) r = REQ_SHUT;
      else if (p < 96) r = REQ_TICK;
      else r = REQ_NONE;
      if ($urandom_range(0, 9) == 0) k = random_key();
      else k = key_pool[$urandom_range(0, pool_sz - 1)];
      send_word(r, k);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_MSG;
    in_src_ip = '0;
    in_src_port = '0;
    in_uuid_upper = '0;
    in_uuid_lower = '0;
    cfg_we = 1'b0;
    cfg_addr = CFG_IDLE_TIMEOUT;
    cfg_wdata = '0;
    burst_left = 0;
    words_sent = 0;
    foreach (key_pool[i]) key_pool[i] = random_key();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: append, hit, removal, missed removal, ignored type, ticks
    send_word(REQ_MSG, key_pool[0]);
    send_word(REQ_MSG, key_pool[0]);
    send_word(REQ_MSG, key_pool[1]);
    send_word(REQ_TICK, key_pool[2]);
    send_word(REQ_MSG, key_pool[2]);
    send_word(REQ_SHUT, key_pool[0]);
    send_word(REQ_SHUT, key_pool[0]);
    send_word(REQ_NONE, key_pool[1]);
    send_word(REQ_MSG, key_pool[1]);
    drain();

    // zero timeout, sweep every tick: each tick ages out every entry
    write_reg(CFG_IDLE_TIMEOUT, 16'd0);
    write_reg(CFG_SWEEP_PERIOD, 16'd1);
    send_word(REQ_MSG, key_pool[3]);
    send_word(REQ_TICK, key_pool[0]);
    send_word(REQ_MSG, key_pool[4]);
    send_word(REQ_MSG, key_pool[5]);
    send_word(REQ_TICK, key_pool[0]);
    send_word(REQ_TICK, key_pool[0]);
    drain();

    // period of zero sweeps on every tick as well
    write_reg(CFG_IDLE_TIMEOUT, 16'd1);
    write_reg(CFG_SWEEP_PERIOD, 16'd0);
    send_word(REQ_MSG, key_pool[6]);
    send_word(REQ_TICK, key_pool[0]);
    send_word(REQ_TICK, key_pool[0]);
    send_word(REQ_TICK, key_pool[0]);
    drain();

    // fill the table, then force replacements of the oldest entry
    write_reg(CFG_IDLE_TIMEOUT, 16'hffff);
    write_reg(CFG_SWEEP_PERIOD, 16'd255);
    for (int i = 10; i < 150; i++) begin
      send_word(REQ_MSG, key_pool[i]);
      if (i % 9 == 0) send_word(REQ_TICK, key_pool[0]);
    end
    random_words(120, 200);
    drain();

    write_reg(CFG_IDLE_TIMEOUT, 16'd20);
    write_reg(CFG_SWEEP_PERIOD, 16'd5);
    random_words(120, 40);
    drain();

    write_reg(CFG_IDLE_TIMEOUT, 16'd3);
    write_reg(CFG_SWEEP_PERIOD, 16'd2);
    random_words(120, 8);
    drain();

    write_reg(CFG_IDLE_TIMEOUT, 16'd300);
    write_reg(CFG_SWEEP_PERIOD, 16'd60);
    random_words(120, 200);
    drain();

    write_reg(CFG_IDLE_TIMEOUT, 16'd40);
    write_reg(CFG_SWEEP_PERIOD, 16'd1);
    random_words(100, 160);
    drain();

    write_reg(CFG_IDLE_TIMEOUT, 16'd0);
    write_reg(CFG_SWEEP_PERIOD, 16'd255);
    random_words(100, 256);
    drain();

    $display("%0d request words, %0d results checked; %0d entries aged out by sweeps",
             words_sent, sb.results, sb.swept_total);
    $display("status mix: hit %0d append %0d replace %0d removed %0d missed %0d tick %0d",
             sb.status_seen[ST_HIT], sb.status_seen[ST_APPEND], sb.status_seen[ST_REPLACE],
             sb.status_seen[ST_REMOVED], sb.status_seen[ST_MISSED], sb.status_seen[ST_TICK]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("session_table_lru_aging_top: match");
    end else begin
      $display("session_table_lru_aging_top: mismatch");
    end
    $finish;
  end
endmodule

`default_nettype wire
